// ===== hdl/csp_pkg.sv =====
`timescale 1ns / 1ps
package csp_pkg;

	localparam logic FN_LOAD  = 1'b0;
	localparam logic FN_QUERY = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_READY = 2'd2;

	typedef struct packed {
		logic               func;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic               last_point;
		logic signed [31:0] distance;
		logic               linear;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] local_t;
		logic [7:0]         segment_index;
		logic [30:0]        path_length;
		logic [1:0]         status;
	} rsp_t;

	// one entry of every store, read together at one address
	typedef struct packed {
		logic [31:0]       knot;
		logic [2:0][31:0]  c;
		logic [2:0][31:0]  p;
		logic [31:0]       sinv;
		logic [31:0]       diag;
		logic [31:0]       rhs;
	} row_t;

endpackage

// ===== hdl/csp_req_if.sv =====
`timescale 1ns / 1ps
interface csp_req_if import csp_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/csp_rsp_if.sv =====
`timescale 1ns / 1ps
interface csp_rsp_if import csp_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/cubic_spline_path_evaluator_core.sv =====
`timescale 1ns / 1ps
// Natural cubic spline path evaluator. Points are loaded one item at a time; each knot is the
// running chord length (integer square root). The item marked last_point then solves the spline
// for all three axes, when at least two points are held, out of synchronous-read stores with one
// read address per cycle, with one shared 32x32 multiplier and one shared radix-2 divider of
// NW = 32+FRAC_BITS quotient bits. A query scans the knots, then interpolates linearly or
// cubically, where the divide by six is a multiply by a reciprocal on the shared multiplier.
// One item is worked at a time; the finished result sits in an output register so the next
// item is taken while it waits. The stores need no clearing after reset.
module cubic_spline_path_evaluator_core import csp_pkg::*; #(
	parameter int MAX_POINTS = 256,
	parameter int FRAC_BITS  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	csp_req_if.sink    req,
	csp_rsp_if.source  rsp
);

	localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int NW  = 32 + FRAC_BITS;
	localparam int DCW = $clog2(NW + 1);

	localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
	localparam logic signed [65:0] SAT_MIN = -(66'sd2147483648);
	localparam logic signed [65:0] HALF    = 66'sd1 <<< (FRAC_BITS - 1);
	localparam logic [31:0]        ONE     = 32'd1 << FRAC_BITS;

	localparam logic [5:0] S_IDLE = 6'd0,  S_OUT  = 6'd1,  S_MW   = 6'd2,  S_FETCH = 6'd3;
	localparam logic [5:0] S_DV0  = 6'd4,  S_DV1  = 6'd5,  S_DV2  = 6'd6;
	localparam logic [5:0] S_LD0  = 6'd7,  S_LD1  = 6'd8,  S_CHM  = 6'd9,  S_CHA   = 6'd10;
	localparam logic [5:0] S_SQI  = 6'd11, S_SQL  = 6'd12, S_SQE  = 6'd13, S_LDWR  = 6'd14;
	localparam logic [5:0] S_LDLAST = 6'd15;
	localparam logic [5:0] S_SA0  = 6'd16, S_SA1  = 6'd17, S_SA2  = 6'd18;
	localparam logic [5:0] S_SB0  = 6'd19, S_SB1  = 6'd20, S_SB2  = 6'd21, S_SB3   = 6'd22;
	localparam logic [5:0] S_SC0  = 6'd23, S_SC1  = 6'd24, S_SC2  = 6'd25, S_SC4   = 6'd26;
	localparam logic [5:0] S_SC6  = 6'd27;
	localparam logic [5:0] S_SD0  = 6'd28, S_SD1  = 6'd29, S_SD2  = 6'd30, S_SD3   = 6'd31;
	localparam logic [5:0] S_SD4  = 6'd32, S_SD5  = 6'd33, S_NXAX = 6'd34;
	localparam logic [5:0] S_Q0   = 6'd35, S_QS   = 6'd36, S_Q1   = 6'd37, S_Q2    = 6'd38;
	localparam logic [5:0] S_Q3   = 6'd39, S_L0   = 6'd40, S_L1   = 6'd41;
	localparam logic [5:0] S_C1   = 6'd42, S_C2   = 6'd43, S_C3   = 6'd44, S_C4    = 6'd45;
	localparam logic [5:0] S_E0   = 6'd46, S_E1   = 6'd47, S_E2   = 6'd48, S_E3    = 6'd49;
	localparam logic [5:0] S_E4   = 6'd50, S_E5   = 6'd51, S_E6   = 6'd52, S_E7    = 6'd53;

	function automatic logic [31:0] sat(input logic signed [65:0] v);
		if (v > SAT_MAX) return 32'h7FFF_FFFF;
		if (v < SAT_MIN) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [31:0] qadd(input logic signed [31:0] a, input logic signed [31:0] b);
		return sat(66'(a) + 66'(b));
	endfunction

	function automatic logic [31:0] qsub(input logic signed [31:0] a, input logic signed [31:0] b);
		return sat(66'(a) - 66'(b));
	endfunction

	function automatic logic [31:0] qdbl(input logic signed [31:0] a);
		return sat(66'(a) * 66'sd2);
	endfunction

	function automatic logic [31:0] qsix(input logic signed [31:0] a);
		return sat(66'(a) * 66'sd6);
	endfunction

	// floor((p + half) / 2^frac), saturated
	function automatic logic [31:0] qmul_fin(input logic signed [63:0] p);
		logic signed [65:0] v;
		v = (66'(p) + HALF) >>> FRAC_BITS;
		return sat(v);
	endfunction

	logic [31:0] knot_mem [MAX_POINTS];
	logic [31:0] sinv_mem [MAX_POINTS];
	logic [31:0] diag_mem [MAX_POINTS];
	logic [31:0] rhs_mem  [MAX_POINTS];
	logic [31:0] coord_mem [3][MAX_POINTS];
	logic [31:0] sd_mem    [3][MAX_POINTS];

	logic [5:0]  state_q, ret_q;
	req_t        rq_q;
	rsp_t        rsp_q;
	logic        rsp_v_q;
	logic [CW-1:0] cnt_q, i_q;
	logic [30:0] rlen_q;
	logic        rdy_q;
	logic [2:0][31:0] prev_q;
	logic [1:0]  st_q, ax_q, ch_q;
	logic [2:0][31:0] pos_q;
	logic [31:0] t_q, s_q, u_q, r_q, ct_q, cs_q, a_q, base_q, dg_q, t1_q, nrhs_q;
	logic [IW-1:0] sg_q, ci_q, fbase_q;
	logic        cv_q;
	logic [1:0]  fc_q, fn_q, cap_i_q;
	logic        cap_v_q;
	row_t        rd_q;
	row_t        slot_q [3];
	logic signed [31:0] ma_q, mb_q;
	logic signed [63:0] prod_q;
	logic [NW-1:0] dnum_q, qr_q;
	logic [31:0] dden_q, dm_q, rm_q, dres_q;
	logic [DCW-1:0] dc_q;
	logic        neg_q, dz_q;
	logic [2:0][30:0] sqv_q;
	logic        sh_q;
	logic [63:0] acc_q, rem_q, res_q, bt_q;

	logic [IW-1:0] ra, wa;
	logic [31:0]   wd_a, wd_b;
	logic          we_knot, we_c, we_sinv, we_diag, we_rhs;
	logic [2:0]    we_p;
	logic [2:0][31:0] pt;
	logic [31:0]   mres, u01, y0, y1, y2, pp0, pp1, g_sum, g_mag, g_six;
	logic [CW:0]   i_ext, n_ext;
	logic          more1, more2, lin_e;
	logic [2:0][32:0] dmag;
	logic          big;
	logic [32:0]   trial;
	logic          ge;
	logic [64:0]   sq_try;
	logic [33:0]   len_sum;

	assign pt    = {rq_q.pz, rq_q.py, rq_q.px};
	assign mres  = qmul_fin(prod_q);
	assign u01   = qsub(slot_q[1].knot, slot_q[0].knot);
	assign y0    = slot_q[0].c[ax_q];
	assign y1    = slot_q[1].c[ax_q];
	assign y2    = slot_q[2].c[ax_q];
	assign pp0   = slot_q[0].p[ax_q];
	assign pp1   = slot_q[1].p[ax_q];
	assign g_sum = qadd(a_q, mres);
	assign g_mag = g_sum[31] ? 32'(0) - g_sum : g_sum;
	// quotient by six sits in the upper word of the reciprocal product
	assign g_six = neg_q ? 32'(0) - prod_q[63:32] : prod_q[63:32];
	assign i_ext = {1'b0, i_q};
	assign n_ext = {1'b0, cnt_q};
	assign more1 = (i_ext + (CW+1)'(1)) < n_ext;
	assign more2 = (i_ext + (CW+1)'(2)) < n_ext;
	assign lin_e = rq_q.linear || (cnt_q == CW'(2));

	// per-axis distance magnitude to the previous point
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [32:0] d;
			d = 33'($signed(pt[k])) - 33'($signed(prev_q[k]));
			dmag[k] = d[32] ? 33'(-d) : 33'(d);
		end
		big = (dmag[0][32:31] != 2'b00) || (dmag[1][32:31] != 2'b00)
			|| (dmag[2][32:31] != 2'b00);
	end

	assign trial  = {rm_q, qr_q[NW-1]};
	assign ge     = trial >= {1'b0, dm_q};
	assign sq_try = {1'b0, res_q} + {1'b0, bt_q};
	assign len_sum = 34'(rlen_q) + 34'({res_q[31:0], 1'b0} >> !sh_q);

	// read address
	always_comb begin
		case (state_q)
			S_FETCH: ra = fbase_q + IW'(fc_q);
			S_QS:    ra = i_q[IW-1:0];
			default: ra = '0;
		endcase
	end

	// write port
	always_comb begin
		we_knot = 1'b0;
		we_c    = 1'b0;
		we_sinv = 1'b0;
		we_diag = 1'b0;
		we_rhs  = 1'b0;
		we_p    = 3'b000;
		wa      = i_q[IW-1:0];
		wd_a    = '0;
		wd_b    = '0;
		case (state_q)
			S_LDWR: begin
				we_knot = 1'b1;
				we_c    = 1'b1;
				wa      = cnt_q[IW-1:0];
				wd_a    = {1'b0, rlen_q};
			end
			S_SA2: begin
				we_sinv = 1'b1;
				wd_a    = dres_q;
			end
			S_SB3: begin
				we_diag = 1'b1;
				we_rhs  = 1'b1;
				wd_a    = dg_q;
				wd_b    = qsix(qsub(t1_q, dres_q));
			end
			S_SC6: begin
				we_diag = 1'b1;
				we_rhs  = 1'b1;
				wa      = IW'(i_q + CW'(1));
				wd_a    = qsub(slot_q[1].diag, mres);
				wd_b    = nrhs_q;
			end
			S_SD0: begin
				we_p[ax_q] = 1'b1;
				wa         = '0;
			end
			S_SD1: begin
				we_p[ax_q] = 1'b1;
				wa         = IW'(cnt_q - CW'(1));
			end
			S_SD5: begin
				we_p[ax_q] = 1'b1;
				wd_a       = dres_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_knot) knot_mem[wa] <= wd_a;
		if (we_sinv) sinv_mem[wa] <= wd_a;
		if (we_diag) diag_mem[wa] <= wd_a;
		if (we_rhs)  rhs_mem[wa]  <= wd_b;
		for (int k = 0; k < 3; k++) begin
			if (we_c)    coord_mem[k][wa] <= pt[k];
			if (we_p[k]) sd_mem[k][wa]    <= wd_a;
		end
		rd_q.knot <= knot_mem[ra];
		rd_q.sinv <= sinv_mem[ra];
		rd_q.diag <= diag_mem[ra];
		rd_q.rhs  <= rhs_mem[ra];
		for (int k = 0; k < 3; k++) begin
			rd_q.c[k] <= coord_mem[k][ra];
			rd_q.p[k] <= sd_mem[k][ra];
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_v_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			rsp_v_q <= 1'b0;
			cnt_q   <= '0;
			rlen_q  <= '0;
			rdy_q   <= 1'b0;
			prev_q  <= '0;
			cv_q    <= 1'b0;
			cap_v_q <= 1'b0;
			fc_q    <= '0;
			fn_q    <= '0;
			dc_q    <= '0;
		end else begin
			prod_q  <= ma_q * mb_q;
			cap_v_q <= (state_q == S_FETCH) && (fc_q != fn_q);
			cap_i_q <= fc_q;
			if (cap_v_q) slot_q[cap_i_q] <= rd_q;
			cv_q <= (state_q == S_QS) && more1;
			ci_q <= i_q[IW-1:0];
			if (cv_q && ($signed(rd_q.knot) <= rq_q.distance)) sg_q <= ci_q;
			if (rsp_v_q && rsp.ready && (state_q != S_OUT)) rsp_v_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						rq_q  <= req.data;
						pos_q <= '0;
						t_q   <= '0;
						sg_q  <= '0;
						st_q  <= ST_OK;
						state_q <= (req.data.func == FN_LOAD) ? S_LD0 : S_Q0;
					end
				end
				S_OUT: begin
					if (!rsp_v_q || rsp.ready) begin
						rsp_q.pos_x         <= pos_q[0];
						rsp_q.pos_y         <= pos_q[1];
						rsp_q.pos_z         <= pos_q[2];
						rsp_q.local_t       <= t_q;
						rsp_q.segment_index <= 8'(sg_q);
						rsp_q.path_length   <= rlen_q;
						rsp_q.status        <= st_q;
						rsp_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MW: state_q <= ret_q;
				S_FETCH: begin
					if (fc_q == fn_q) state_q <= ret_q;
					else fc_q <= fc_q + 2'd1;
				end
				S_DV0: begin
					neg_q <= dnum_q[NW-1] ^ dden_q[31];
					dz_q  <= (dden_q == '0);
					qr_q  <= dnum_q[NW-1] ? NW'(-dnum_q) : dnum_q;
					dm_q  <= dden_q[31] ? 32'(-dden_q) : dden_q;
					rm_q  <= '0;
					dc_q  <= DCW'(NW);
					state_q <= S_DV1;
				end
				S_DV1: begin
					rm_q <= ge ? 32'(trial - {1'b0, dm_q}) : trial[31:0];
					qr_q <= {qr_q[NW-2:0], ge};
					dc_q <= dc_q - DCW'(1);
					if (dc_q == DCW'(1)) state_q <= S_DV2;
				end
				S_DV2: begin
					if (dz_q) dres_q <= '0;
					else if (neg_q) begin
						if (qr_q > NW'(33'h0_8000_0000)) dres_q <= 32'h8000_0000;
						else dres_q <= 32'(0) - qr_q[31:0];
					end else begin
						if (qr_q > NW'(32'h7FFF_FFFF)) dres_q <= 32'h7FFF_FFFF;
						else dres_q <= qr_q[31:0];
					end
					state_q <= ret_q;
				end

				// point load
				S_LD0: begin
					if (rdy_q) begin
						cnt_q  <= '0;
						rlen_q <= '0;
						rdy_q  <= 1'b0;
					end
					state_q <= S_LD1;
				end
				S_LD1: begin
					if (cnt_q == CW'(MAX_POINTS)) begin
						st_q    <= ST_FULL;
						state_q <= S_LDLAST;
					end else if (cnt_q == '0) begin
						rlen_q  <= '0;
						state_q <= S_LDWR;
					end else begin
						for (int k = 0; k < 3; k++)
							sqv_q[k] <= big ? dmag[k][31:1] : dmag[k][30:0];
						sh_q    <= big;
						acc_q   <= '0;
						ch_q    <= '0;
						state_q <= S_CHM;
					end
				end
				S_CHM: begin
					ma_q    <= {1'b0, sqv_q[ch_q]};
					mb_q    <= {1'b0, sqv_q[ch_q]};
					ret_q   <= S_CHA;
					state_q <= S_MW;
				end
				S_CHA: begin
					acc_q <= acc_q + prod_q;
					if (ch_q == 2'd2) state_q <= S_SQI;
					else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= S_CHM;
					end
				end
				S_SQI: begin
					rem_q   <= acc_q;
					res_q   <= '0;
					bt_q    <= 64'd1 << 62;
					state_q <= S_SQL;
				end
				S_SQL: begin
					if ({1'b0, rem_q} >= sq_try) begin
						rem_q <= 64'({1'b0, rem_q} - sq_try);
						res_q <= (res_q >> 1) + bt_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bt_q <= bt_q >> 2;
					if (bt_q[0]) state_q <= S_SQE;
				end
				S_SQE: begin
					rlen_q  <= (len_sum > 34'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : len_sum[30:0];
					state_q <= S_LDWR;
				end
				S_LDWR: begin
					prev_q  <= pt;
					cnt_q   <= cnt_q + CW'(1);
					state_q <= S_LDLAST;
				end
				S_LDLAST: begin
					if (rq_q.last_point && (cnt_q >= CW'(2))) begin
						i_q     <= '0;
						state_q <= S_SA0;
					end else begin
						if (rq_q.last_point && (st_q == ST_OK)) st_q <= ST_NOT_READY;
						state_q <= S_OUT;
					end
				end

				// span inverses
				S_SA0: begin
					fbase_q <= i_q[IW-1:0];
					fn_q    <= 2'd2;
					fc_q    <= '0;
					ret_q   <= S_SA1;
					state_q <= S_FETCH;
				end
				S_SA1: begin
					dnum_q  <= {ONE, {FRAC_BITS{1'b0}}};
					dden_q  <= u01;
					ret_q   <= S_SA2;
					state_q <= S_DV0;
				end
				S_SA2: begin
					if (more2) begin
						i_q     <= i_q + CW'(1);
						state_q <= S_SA0;
					end else begin
						ax_q    <= '0;
						i_q     <= CW'(1);
						state_q <= S_SB0;
					end
				end

				// tridiagonal setup for one axis
				S_SB0: begin
					if (!more1) begin
						i_q     <= CW'(1);
						state_q <= S_SC0;
					end else begin
						fbase_q <= IW'(i_q - CW'(1));
						fn_q    <= 2'd3;
						fc_q    <= '0;
						ret_q   <= S_SB1;
						state_q <= S_FETCH;
					end
				end
				S_SB1: begin
					dg_q    <= qdbl(qsub(slot_q[2].knot, slot_q[0].knot));
					dnum_q  <= {qsub(y2, y1), {FRAC_BITS{1'b0}}};
					dden_q  <= qsub(slot_q[2].knot, slot_q[1].knot);
					ret_q   <= S_SB2;
					state_q <= S_DV0;
				end
				S_SB2: begin
					t1_q    <= dres_q;
					dnum_q  <= {qsub(y1, y0), {FRAC_BITS{1'b0}}};
					dden_q  <= u01;
					ret_q   <= S_SB3;
					state_q <= S_DV0;
				end
				S_SB3: begin
					i_q     <= i_q + CW'(1);
					state_q <= S_SB0;
				end

				// forward elimination
				S_SC0: begin
					if (!more2) state_q <= S_SD0;
					else begin
						fbase_q <= i_q[IW-1:0];
						fn_q    <= 2'd2;
						fc_q    <= '0;
						ret_q   <= S_SC1;
						state_q <= S_FETCH;
					end
				end
				S_SC1: begin
					u_q     <= u01;
					dnum_q  <= {u01, {FRAC_BITS{1'b0}}};
					dden_q  <= slot_q[0].diag;
					ret_q   <= S_SC2;
					state_q <= S_DV0;
				end
				S_SC2: begin
					r_q     <= dres_q;
					ma_q    <= slot_q[0].rhs;
					mb_q    <= dres_q;
					ret_q   <= S_SC4;
					state_q <= S_MW;
				end
				S_SC4: begin
					nrhs_q  <= qsub(slot_q[1].rhs, mres);
					ma_q    <= u_q;
					mb_q    <= r_q;
					ret_q   <= S_SC6;
					state_q <= S_MW;
				end
				S_SC6: begin
					i_q     <= i_q + CW'(1);
					state_q <= S_SC0;
				end

				// back substitution, end knots held at zero
				S_SD0: state_q <= S_SD1;
				S_SD1: begin
					i_q     <= cnt_q - CW'(2);
					state_q <= S_SD2;
				end
				S_SD2: begin
					if (i_q == '0) state_q <= S_NXAX;
					else begin
						fbase_q <= i_q[IW-1:0];
						fn_q    <= 2'd2;
						fc_q    <= '0;
						ret_q   <= S_SD3;
						state_q <= S_FETCH;
					end
				end
				S_SD3: begin
					ma_q    <= u01;
					mb_q    <= pp1;
					ret_q   <= S_SD4;
					state_q <= S_MW;
				end
				S_SD4: begin
					dnum_q  <= {qsub(slot_q[0].rhs, mres), {FRAC_BITS{1'b0}}};
					dden_q  <= slot_q[0].diag;
					ret_q   <= S_SD5;
					state_q <= S_DV0;
				end
				S_SD5: begin
					i_q     <= i_q - CW'(1);
					state_q <= S_SD2;
				end
				S_NXAX: begin
					if (ax_q == 2'd2) begin
						rdy_q   <= 1'b1;
						state_q <= S_OUT;
					end else begin
						ax_q    <= ax_q + 2'd1;
						i_q     <= CW'(1);
						state_q <= S_SB0;
					end
				end

				// query
				S_Q0: begin
					if (!rdy_q) begin
						st_q    <= ST_NOT_READY;
						state_q <= S_OUT;
					end else begin
						i_q     <= CW'(1);
						state_q <= S_QS;
					end
				end
				S_QS: begin
					if (more1) i_q <= i_q + CW'(1);
					else state_q <= S_Q1;
				end
				S_Q1: begin
					fbase_q <= sg_q;
					fn_q    <= 2'd2;
					fc_q    <= '0;
					ret_q   <= S_Q2;
					state_q <= S_FETCH;
				end
				S_Q2: begin
					u_q     <= u01;
					ma_q    <= qsub(rq_q.distance, slot_q[0].knot);
					mb_q    <= slot_q[0].sinv;
					ret_q   <= S_Q3;
					state_q <= S_MW;
				end
				S_Q3: begin
					t_q  <= mres;
					s_q  <= qsub(ONE, mres);
					ax_q <= '0;
					if (lin_e) state_q <= S_L0;
					else begin
						ma_q    <= mres;
						mb_q    <= mres;
						ret_q   <= S_C1;
						state_q <= S_MW;
					end
				end
				S_L0: begin
					ma_q    <= qsub(y1, y0);
					mb_q    <= t_q;
					ret_q   <= S_L1;
					state_q <= S_MW;
				end
				S_L1: begin
					pos_q[ax_q] <= qadd(y0, mres);
					if (ax_q == 2'd2) state_q <= S_OUT;
					else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_L0;
					end
				end
				S_C1: begin
					ma_q    <= mres;
					mb_q    <= t_q;
					ret_q   <= S_C2;
					state_q <= S_MW;
				end
				S_C2: begin
					ct_q    <= qsub(mres, t_q);
					ma_q    <= s_q;
					mb_q    <= s_q;
					ret_q   <= S_C3;
					state_q <= S_MW;
				end
				S_C3: begin
					ma_q    <= mres;
					mb_q    <= s_q;
					ret_q   <= S_C4;
					state_q <= S_MW;
				end
				S_C4: begin
					cs_q    <= qsub(mres, s_q);
					state_q <= S_E0;
				end
				S_E0: begin
					ma_q    <= t_q;
					mb_q    <= y1;
					ret_q   <= S_E1;
					state_q <= S_MW;
				end
				S_E1: begin
					a_q     <= mres;
					ma_q    <= s_q;
					mb_q    <= y0;
					ret_q   <= S_E2;
					state_q <= S_MW;
				end
				S_E2: begin
					base_q  <= qadd(a_q, mres);
					ma_q    <= ct_q;
					mb_q    <= pp1;
					ret_q   <= S_E3;
					state_q <= S_MW;
				end
				S_E3: begin
					a_q     <= mres;
					ma_q    <= cs_q;
					mb_q    <= pp0;
					ret_q   <= S_E4;
					state_q <= S_MW;
				end
				S_E4: begin
					// divide by six toward zero: halve the magnitude, then times ceil(2^32/3)
					neg_q   <= g_sum[31];
					ma_q    <= {1'b0, g_mag[31:1]};
					mb_q    <= 32'sh5555_5556;
					ret_q   <= S_E5;
					state_q <= S_MW;
				end
				S_E5: begin
					ma_q    <= u_q;
					mb_q    <= g_six;
					ret_q   <= S_E6;
					state_q <= S_MW;
				end
				S_E6: begin
					ma_q    <= u_q;
					mb_q    <= mres;
					ret_q   <= S_E7;
					state_q <= S_MW;
				end
				S_E7: begin
					pos_q[ax_q] <= qadd(base_q, mres);
					if (ax_q == 2'd2) state_q <= S_OUT;
					else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_E0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sim/spline_result_watch.sv =====
`timescale 1ns / 1ps
module spline_result_watch import csp_pkg::*; #(
	parameter int MAX_POINTS = 256,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	csp_req_if   req,
	csp_rsp_if   rsp,
	output int   errors,
	output int   pending
);

	localparam longint ONE_Q  = longint'(1) <<< FRAC_BITS;
	localparam longint HALF_Q = longint'(1) <<< (FRAC_BITS - 1);

	int knot [MAX_POINTS];
	int cx [MAX_POINTS];
	int cy [MAX_POINTS];
	int cz [MAX_POINTS];
	int dx [MAX_POINTS];
	int dy [MAX_POINTS];
	int dz [MAX_POINTS];
	int sinv [MAX_POINTS];
	int diag [MAX_POINTS];
	int rhs [MAX_POINTS];
	int held;
	int run_len;
	int prev [3];
	bit ready_flag;

	rsp_t expected_rsps [$];

	function automatic int sat(longint v);
		if (v > 64'sh7FFF_FFFF)
			return 32'h7FFF_FFFF;
		if (v < -64'sh8000_0000)
			return 32'h8000_0000;
		return int'(v);
	endfunction

	function automatic int qadd(int a, int b);
		return sat(longint'(a) + longint'(b));
	endfunction

	function automatic int qsub(int a, int b);
		return sat(longint'(a) - longint'(b));
	endfunction

	function automatic int qmul(int a, int b);
		return sat((longint'(a) * longint'(b) + HALF_Q) >>> FRAC_BITS);
	endfunction

	function automatic int qdiv(int a, int b);
		if (b == 0)
			return 0;
		return sat((longint'(a) * ONE_Q) / longint'(b));
	endfunction

	function automatic bit [63:0] isqrt(bit [63:0] v);
		bit [63:0] res;
		bit [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic bit [63:0] chord_len(int x, int y, int z);
		longint d [3];
		bit [63:0] m [3];
		int s;
		d[0] = longint'(x) - longint'(prev[0]);
		d[1] = longint'(y) - longint'(prev[1]);
		d[2] = longint'(z) - longint'(prev[2]);
		s = 0;
		for (int k = 0; k < 3; k++) begin
			m[k] = (d[k] < 0) ? -d[k] : d[k];
			if (m[k] >= 64'h8000_0000)
				s = 1;
		end
		for (int k = 0; k < 3; k++)
			m[k] = m[k] >> s;
		return isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]) << s;
	endfunction

	function automatic int span(int i);
		return qsub(knot[i + 1], knot[i]);
	endfunction

	function automatic void solve_axis(ref int y [MAX_POINTS], ref int p [MAX_POINTS], input int n);
		int r;
		for (int i = 1; i + 1 < n; i++) begin
			diag[i] = sat(longint'(qsub(knot[i + 1], knot[i - 1])) * 2);
			rhs[i] = sat(longint'(qsub(qdiv(qsub(y[i + 1], y[i]), span(i)),
				qdiv(qsub(y[i], y[i - 1]), span(i - 1)))) * 6);
		end
		for (int i = 1; i + 2 < n; i++) begin
			r = qdiv(span(i), diag[i]);
			rhs[i + 1] = qsub(rhs[i + 1], qmul(rhs[i], r));
			diag[i + 1] = qsub(diag[i + 1], qmul(span(i), r));
		end
		p[0] = 0;
		p[n - 1] = 0;
		for (int i = n - 2; i > 0; i--)
			p[i] = qdiv(qsub(rhs[i], qmul(span(i), p[i + 1])), diag[i]);
	endfunction

	function automatic int cube_less(int a);
		return qsub(qmul(qmul(a, a), a), a);
	endfunction

	function automatic int eval_axis(ref int y [MAX_POINTS], ref int p [MAX_POINTS],
			input int i, input int t, input bit lin);
		int s;
		int base;
		int g;
		if (lin)
			return qadd(y[i], qmul(qsub(y[i + 1], y[i]), t));
		s = qsub(int'(ONE_Q), t);
		base = qadd(qmul(t, y[i + 1]), qmul(s, y[i]));
		g = qadd(qmul(cube_less(t), p[i + 1]), qmul(cube_less(s), p[i])) / 6;
		return qadd(base, qmul(span(i), qmul(span(i), g)));
	endfunction

	function automatic rsp_t evaluate_item(req_t it);
		rsp_t o;
		bit [63:0] len;
		int seg;
		int t;
		bit lin;
		o = '0;
		seg = 0;
		t = 0;
		if (it.func == FN_LOAD) begin
			if (ready_flag) begin
				held = 0;
				run_len = 0;
				ready_flag = 0;
			end
			if (held >= MAX_POINTS) begin
				o.status = ST_FULL;
			end else begin
				if (held == 0) begin
					run_len = 0;
				end else begin
					len = 64'(unsigned'(run_len)) + chord_len(it.px, it.py, it.pz);
					run_len = (len > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : int'(len);
				end
				knot[held] = run_len;
				cx[held] = it.px;
				cy[held] = it.py;
				cz[held] = it.pz;
				prev[0] = it.px;
				prev[1] = it.py;
				prev[2] = it.pz;
				held++;
			end
			if (it.last_point) begin
				if (held >= 2) begin
					for (int i = 0; i + 1 < held; i++)
						sinv[i] = qdiv(int'(ONE_Q), span(i));
					solve_axis(cx, dx, held);
					solve_axis(cy, dy, held);
					solve_axis(cz, dz, held);
					ready_flag = 1;
				end else if (o.status == ST_OK) begin
					o.status = ST_NOT_READY;
				end
			end
		end else if (!ready_flag) begin
			o.status = ST_NOT_READY;
		end else begin
			lin = it.linear || held == 2;
			for (int i = 1; i + 1 < held; i++)
				if (knot[i] <= it.distance)
					seg = i;
			t = qmul(qsub(it.distance, knot[seg]), sinv[seg]);
			o.pos_x = eval_axis(cx, dx, seg, t, lin);
			o.pos_y = eval_axis(cy, dy, seg, t, lin);
			o.pos_z = eval_axis(cz, dz, seg, t, lin);
		end
		o.local_t = t;
		o.segment_index = seg[7:0];
		o.path_length = run_len[30:0];
		return o;
	endfunction

	task automatic compare_field(string name, longint e, longint a);
		if (e != a) begin
			$display("%0t mismatch %s expected %0d actual %0d", $time, name, e, a);
			errors++;
		end
	endtask

	initial begin
		errors = 0;
		held = 0;
		run_len = 0;
		ready_flag = 0;
		prev = '{0, 0, 0};
	end

	assign pending = expected_rsps.size();

	always @(posedge clk) begin
		rsp_t e;
		rsp_t a;
		if (arst_n) begin
			if (req.valid && req.ready)
				expected_rsps.push_back(evaluate_item(req.data));
			if (rsp.valid && rsp.ready) begin
				a = rsp.data;
				if (expected_rsps.size() == 0) begin
					$display("%0t unexpected result status %0d", $time, a.status);
					errors++;
				end else begin
					e = expected_rsps.pop_front();
					compare_field("pos_x", e.pos_x, a.pos_x);
					compare_field("pos_y", e.pos_y, a.pos_y);
					compare_field("pos_z", e.pos_z, a.pos_z);
					compare_field("local_t", e.local_t, a.local_t);
					compare_field("segment_index", e.segment_index, a.segment_index);
					compare_field("path_length", e.path_length, a.path_length);
					compare_field("status", e.status, a.status);
				end
			end
		end
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import csp_pkg::*;

	logic clk;
	logic arst_n;
	int errors;
	int pending;
	int sent;
	int burst_left;

	csp_req_if req_ch ();
	csp_rsp_if rsp_ch ();

	cubic_spline_path_evaluator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	spline_result_watch watch (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.errors(errors),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// receiver stall pattern: phases of free flow, light and heavy backpressure
	int stall_mode;
	int stall_left;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(1, 60);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: begin
				rsp_ch.ready <= 1'b1;
			end
			1: begin
				rsp_ch.ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				rsp_ch.ready <= ($urandom_range(0, 4) == 0);
			end
		endcase
	end

	task automatic send(req_t it);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sent++;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			burst_left = $urandom_range(0, 20);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	function automatic req_t noise_item();
		req_t it;
		it.func = 1'b0;
		it.px = $urandom;
		it.py = $urandom;
		it.pz = $urandom;
		it.last_point = 1'b0;
		it.distance = $urandom;
		it.linear = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic req_t point_item(int x, int y, int z, bit last);
		req_t it;
		it = noise_item();
		it.func = FN_LOAD;
		it.px = x;
		it.py = y;
		it.pz = z;
		it.last_point = last;
		return it;
	endfunction

	function automatic req_t query_item(int d, bit lin);
		req_t it;
		it = noise_item();
		it.func = FN_QUERY;
		it.distance = d;
		it.linear = lin;
		return it;
	endfunction

	function automatic int small_coord();
		return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
	endfunction

	function automatic int query_dist();
		if ($urandom_range(0, 6) == 0)
			return $urandom;
		return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0020_0000;
	endfunction

	task automatic random_path();
		int n;
		int mode;
		int x;
		int y;
		int z;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 6);
		mode = $urandom_range(0, 4);
		x = 0;
		y = 0;
		z = 0;
		for (int i = 0; i < n; i++) begin
			// occasionally repeat the previous point for a zero-length span
			if (i == 0 || $urandom_range(0, 9) != 0) begin
				if (mode == 0) begin
					x = $urandom;
					y = $urandom;
					z = $urandom;
				end else begin
					x = small_coord();
					y = small_coord();
					z = small_coord();
				end
			end
			send(point_item(x, y, z, i == n - 1));
		end
		repeat ($urandom_range(3, 14))
			send(query_item(query_dist(), 1'($urandom_range(0, 1))));
	endtask

	initial begin
		req_t it;
		sent = 0;
		burst_left = 0;
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// query before any solve, then last point with a single point held
		send(query_item(0, 1'b0));
		send(point_item(32'sh0001_0000, 0, 0, 1'b1));
		send(query_item(32'sh7FFF_FFFF, 1'b0));
		// two points: linear forced
		send(point_item(32'sh0003_0000, 32'sh0004_0000, 0, 1'b1));
		send(query_item(32'sh0002_8000, 1'b0));
		send(query_item(32'sh8000_0000, 1'b0));
		send(query_item(32'sh7FFF_FFFF, 1'b1));
		// extreme coordinates with a zero-length span, length saturates
		send(point_item(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0));
		send(point_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0));
		send(point_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0));
		send(point_item(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1));
		send(query_item(0, 1'b0));
		send(query_item(32'sh7FFF_FFFF, 1'b0));
		send(query_item(32'sh8000_0000, 1'b1));
		// ordinary cubic path
		send(point_item(0, 0, 0, 1'b0));
		send(point_item(32'sh0002_0000, 32'sh0001_0000, 0, 1'b0));
		send(point_item(32'sh0004_0000, 32'sh0000_0000, 32'sh0001_0000, 1'b0));
		send(point_item(32'sh0006_0000, 32'shFFFF_0000, 32'sh0002_0000, 1'b1));
		send(query_item(32'sh0001_8000, 1'b0));
		send(query_item(32'sh0003_0000, 1'b0));
		send(query_item(32'sh0003_0000, 1'b1));
		send(query_item(32'sh0010_0000, 1'b0));

		// full point table, the offered extra point finalizes the path
		for (int i = 0; i < 256; i++)
			send(point_item(small_coord() >>> 4, small_coord() >>> 4, small_coord() >>> 4, 1'b0));
		send(point_item(small_coord(), small_coord(), small_coord(), 1'b1));
		repeat (5)
			send(query_item(query_dist(), 1'($urandom_range(0, 1))));

		while (sent < 1500) begin
			if ($urandom_range(0, 6) != 0) begin
				random_path();
			end else begin
				// broken sequences: unfinished path queried, lone last points, garbage
				repeat ($urandom_range(1, 4)) begin
					it = noise_item();
					if ($urandom_range(0, 1))
						it.func = FN_QUERY;
					else
						it.last_point = 1'($urandom_range(0, 1));
					send(it);
				end
			end
		end
		req_ch.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (2000) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#80_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
